FILE: sv/vtt_pkg.sv
package vtt_pkg;
    localparam int COLUMNS = 32;
    localparam int ROWS = 16;
    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int AW = CW + RW;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_ESCAPE = 2'd0;
    localparam logic [1:0] REG_ROW_OFS = 2'd1;
    localparam logic [1:0] REG_COL_OFS = 2'd2;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_J = 8'h4A;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_Y = 8'h59;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
endpackage

FILE: sv/vt52_text_terminal.sv
// VT52-style text terminal over a 16x32 character store in one RAM.
// Accept a command with start while busy is low; exactly one result beat
// follows on o_done for one cycle and must be taken then, since the receiver
// cannot stall. A scroll copies the store a row up one cell at a time through
// the one RAM, each cell read and then written, and then blanks the bottom
// row one cell a cycle; clear-screen and erase sweeps write one cell a cycle.
// A flush renders each held byte in turn, with a scroll where one falls due.
// After reset a clearing pass writes every cell before busy drops.
module vt52_text_terminal
    import vtt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_command,
    input  logic [7:0] i_byte_in,
    input  logic [3:0] i_read_row,
    input  logic [4:0] i_read_col,
    output logic       o_done,
    output logic [7:0] o_cell_value,
    output logic [4:0] o_cursor_col,
    output logic [3:0] o_cursor_row,
    output logic       o_in_escape
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_READ2, S_RENDER, S_SCR_RD, S_SCR_WR,
        S_FILL, S_DONE
    } t_state;

    t_state      r_state;
    logic [7:0]  r_esc, r_rofs, r_cofs;
    logic [CW-1:0] r_cx;
    logic [RW-1:0] r_cy;
    logic        r_mode;
    logic [7:0]  r_seq [3];
    logic [1:0]  r_len;
    logic [1:0]  r_fl_n, r_fl_i;   // flush bytes left to render, next byte index
    logic        r_flush;
    logic [7:0]  r_ch;             // byte to render
    logic [AW:0] r_ptr, r_end;     // sweep pointer and end
    logic        r_oor;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [7:0]      wdata, rdata;

    vtt_ram #(.WIDTH(8), .DEPTH(CELLS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign busy = (r_state != S_IDLE);

    logic [AW-1:0] cur_addr;
    assign cur_addr = {r_cy, r_cx};

    // memory port drive
    always_comb begin
        we = 1'b0;
        waddr = r_ptr[AW-1:0];
        wdata = 8'd0;
        raddr = r_ptr[AW-1:0];
        case (r_state)
            S_CLEAR, S_FILL: we = 1'b1;
            S_RENDER: begin
                we = (r_ch != 8'd0) && (r_ch != CH_LF) && (r_ch != CH_CR);
                waddr = cur_addr;
                wdata = r_ch;
            end
            S_SCR_RD: raddr = r_ptr[AW-1:0] + AW'(COLUMNS);
            S_SCR_WR: begin
                we = 1'b1;
                wdata = rdata;
            end
            default: ;
        endcase
    end

    logic [8:0] yr, yc;
    assign yr = {1'b0, r_seq[2]} - {1'b0, r_rofs};
    assign yc = {1'b0, i_byte_in} - {1'b0, r_cofs};

    // rendered byte ends the line: line control or text in the last column
    logic line_end;
    assign line_end = (r_ch == CH_LF) || (r_ch == CH_CR) ||
                      ((r_ch != 8'd0) && (r_cx == CW'(COLUMNS-1)));

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_esc <= 8'd27; r_rofs <= 8'd32; r_cofs <= 8'd32;
            r_cx <= '0; r_cy <= '0; r_mode <= 1'b0; r_len <= 2'd0;
            r_ptr <= '0; r_end <= (AW+1)'(CELLS); r_flush <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ESCAPE:  r_esc <= i_cfg_data;
                    REG_ROW_OFS: r_rofs <= i_cfg_data;
                    REG_COL_OFS: r_cofs <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr + 1'b1 == r_end) r_state <= S_IDLE;
                end
                S_IDLE: if (start) begin
                    o_cell_value <= 8'd0;
                    case (t_cmd'(i_command))
                        CMD_READ: begin
                            r_ptr <= {1'b0, i_read_row, i_read_col};
                            r_oor <= ({28'd0, i_read_row} >= ROWS) ||
                                     ({27'd0, i_read_col} >= COLUMNS);
                            r_state <= S_READ;
                        end
                        CMD_FLUSH: begin
                            if (r_mode) begin
                                r_mode <= 1'b0; r_len <= 2'd0;
                                r_fl_n <= r_len - 1'b1; r_fl_i <= 2'd1;
                                r_ch <= r_seq[0]; r_flush <= 1'b1;
                                r_state <= S_RENDER;
                            end else r_state <= S_DONE;
                        end
                        CMD_WRITE: begin
                            r_state <= S_DONE;
                            if (!r_mode) begin
                                if (i_byte_in == r_esc) begin
                                    r_mode <= 1'b1; r_seq[0] <= i_byte_in;
                                    r_len <= 2'd1;
                                end else begin
                                    r_ch <= i_byte_in; r_flush <= 1'b0;
                                    r_fl_n <= 2'd0;
                                    r_state <= S_RENDER;
                                end
                            end else if (r_len == 2'd1) begin
                                if (i_byte_in == CH_Y) begin
                                    r_seq[1] <= i_byte_in; r_len <= 2'd2;
                                end else begin
                                    r_mode <= 1'b0; r_len <= 2'd0;
                                    case (i_byte_in)
                                        CH_A: if (r_cy != 0) r_cy <= r_cy - 1'b1;
                                        CH_B: if (r_cy != RW'(ROWS-1)) r_cy <= r_cy + 1'b1;
                                        CH_C: if (r_cx != CW'(COLUMNS-1)) r_cx <= r_cx + 1'b1;
                                        CH_D: if (r_cx != 0) r_cx <= r_cx - 1'b1;
                                        CH_E: begin
                                            r_cx <= '0; r_cy <= '0; r_ptr <= '0;
                                            r_end <= (AW+1)'(CELLS);
                                            r_state <= S_FILL;
                                        end
                                        CH_H: begin r_cx <= '0; r_cy <= '0; end
                                        CH_J: begin
                                            r_ptr <= {1'b0, cur_addr};
                                            r_end <= (AW+1)'(CELLS);
                                            r_state <= S_FILL;
                                        end
                                        CH_K: begin
                                            r_ptr <= {1'b0, cur_addr};
                                            r_end <= {1'b0, r_cy, CW'(0)} +
                                                     (AW+1)'(COLUMNS);
                                            r_state <= S_FILL;
                                        end
                                        default: ;
                                    endcase
                                end
                            end else if (r_len == 2'd2) begin
                                r_seq[2] <= i_byte_in; r_len <= 2'd3;
                            end else begin
                                r_mode <= 1'b0; r_len <= 2'd0;
                                if (!yr[8] && yr < 9'(ROWS) && !yc[8] &&
                                    yc < 9'(COLUMNS)) begin
                                    r_cy <= yr[RW-1:0]; r_cx <= yc[CW-1:0];
                                end
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_READ: r_state <= S_READ2;
                S_READ2: begin
                    o_cell_value <= r_oor ? 8'd0 : rdata;
                    r_state <= S_DONE;
                end
                S_RENDER: begin
                    // advance cursor, scroll at bottom
                    r_state <= S_DONE;
                    if (line_end) begin
                        r_cx <= '0;
                        if (r_cy == RW'(ROWS-1)) begin
                            r_ptr <= '0; r_state <= S_SCR_RD;
                        end else r_cy <= r_cy + 1'b1;
                    end else if (r_ch != 8'd0) r_cx <= r_cx + 1'b1;
                    // take the next held byte unless a scroll runs first
                    if (r_flush && r_fl_n != 0 &&
                        !(line_end && r_cy == RW'(ROWS-1))) begin
                        r_fl_n <= r_fl_n - 1'b1; r_fl_i <= r_fl_i + 1'b1;
                        r_ch <= r_seq[r_fl_i];
                        r_state <= S_RENDER;
                    end
                end
                S_SCR_RD: r_state <= S_SCR_WR;
                S_SCR_WR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr + 1'b1 == (AW+1)'(CELLS - COLUMNS)) begin
                        r_end <= (AW+1)'(CELLS);
                        r_ptr <= (AW+1)'(CELLS - COLUMNS);
                        r_state <= S_FILL;
                    end else r_state <= S_SCR_RD;
                end
                S_FILL: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr + 1'b1 >= r_end) begin
                        // resume a pending flush after a scroll
                        if (r_flush && r_fl_n != 0) begin
                            r_fl_n <= r_fl_n - 1'b1; r_fl_i <= r_fl_i + 1'b1;
                            r_ch <= r_seq[r_fl_i];
                            r_state <= S_RENDER;
                        end else r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_done <= 1'b1; r_flush <= 1'b0; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cursor_col = r_cx;
    assign o_cursor_row = r_cy;
    assign o_in_escape = r_mode;
endmodule

FILE: sv/vtt_ram.sv
module vtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
